>>> sv/tma_pkg.sv
package tma_pkg;

   localparam int TMA_WINDOW_SIZE = 10;
   localparam int TEMP_W          = 9;
   localparam int TEMP_MAX        = 511;
   localparam int RECIP_SHIFT     = 20;

   localparam logic [TEMP_W-1:0] STEP_SIZE    = 9'd5;
   localparam logic [TEMP_W-1:0] SETPOINT_TOP = 9'd511;

   localparam logic [TEMP_W-1:0] MIN_SETPOINT_RST     = 9'd35;
   localparam logic [TEMP_W-1:0] MAX_SETPOINT_RST     = 9'd75;
   localparam logic [TEMP_W-1:0] MARGIN_RST           = 9'd5;
   localparam logic [TEMP_W-1:0] INITIAL_SETPOINT_RST = 9'd60;

   typedef enum logic [1:0] {
      CSR_MIN_SETPOINT     = 2'd0,
      CSR_MAX_SETPOINT     = 2'd1,
      CSR_MARGIN           = 2'd2,
      CSR_INITIAL_SETPOINT = 2'd3
   } tma_csr_type;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_UP     = 2'd1,
      CMD_DOWN   = 2'd2,
      CMD_LEAVE  = 2'd3
   } tma_cmd_type;

   typedef struct packed {
      logic [TEMP_W-1:0] average;
      logic [TEMP_W-1:0] latest;
      logic [TEMP_W-1:0] setpoint;
      logic              setting;
   } tma_state_type;

   typedef struct packed {
      logic              heater_on;
      logic              cooler_on;
      logic              lamp_on;
      logic              display_on;
      logic [TEMP_W-1:0] display_value;
      logic              in_setting;
      logic [TEMP_W-1:0] current_setpoint;
      logic [TEMP_W-1:0] average_temp;
   } tma_result_type;

endpackage

>>> sv/tma_core.sv
module tma_core import tma_pkg::*; #(
   parameter int WINDOW_SIZE = TMA_WINDOW_SIZE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          command,
   input  logic [9:0]          adc_reading,
   input  logic                sp_load,
   input  logic [TEMP_W-1:0]   sp_load_value,
   input  logic [TEMP_W-1:0]   min_setpoint,
   input  logic [TEMP_W-1:0]   max_setpoint,
   output tma_state_type       state,
   output logic                moved
);

   localparam int SLOT_W  = $clog2(WINDOW_SIZE);
   localparam int SUM_W   = $clog2(TEMP_MAX * WINDOW_SIZE + 1);
   localparam int RECIP   = ((1 << RECIP_SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE;
   localparam int PROD_W  = SUM_W + RECIP_SHIFT;

   logic [TEMP_W-1:0] window_ff [WINDOW_SIZE];
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [TEMP_W-1:0] latest_ff, latest_in;
   logic [TEMP_W-1:0] setpoint_ff, setpoint_in;
   logic              setting_ff, setting_in;
   logic              primed_ff, primed_in;

   tma_cmd_type       cmd;
   logic [TEMP_W-1:0] temp;
   logic [TEMP_W:0]   step_up;
   logic              do_sample;
   logic [PROD_W-1:0] product;

   assign cmd       = tma_cmd_type'(command);
   assign temp      = adc_reading[9:1];
   assign step_up   = {1'b0, setpoint_ff} + {1'b0, STEP_SIZE};
   assign do_sample = accept && !setting_ff && (cmd == CMD_SAMPLE);

   always_comb begin
      slot_in     = slot_ff;
      sum_in      = sum_ff;
      latest_in   = latest_ff;
      setpoint_in = setpoint_ff;
      setting_in  = setting_ff;
      primed_in   = primed_ff;
      moved       = 1'b0;
      if (accept) begin
         if (!setting_ff) begin
            case (cmd)
               CMD_SAMPLE: begin
                  latest_in = temp;
                  if (!primed_ff) begin
                     sum_in    = SUM_W'(temp) * SUM_W'(WINDOW_SIZE);
                     slot_in   = '0;
                     primed_in = 1'b1;
                  end else begin
                     sum_in  = sum_ff - SUM_W'(window_ff[slot_ff]) + SUM_W'(temp);
                     slot_in = (slot_ff == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_ff + 1'b1;
                  end
               end
               CMD_UP, CMD_DOWN: begin
                  setting_in = 1'b1;
               end
               default: begin
               end
            endcase
         end else begin
            case (cmd)
               CMD_UP: begin
                  if (setpoint_ff < max_setpoint) begin
                     setpoint_in = (step_up > {1'b0, SETPOINT_TOP}) ? SETPOINT_TOP
                                                                    : step_up[TEMP_W-1:0];
                     moved       = 1'b1;
                  end
               end
               CMD_DOWN: begin
                  if (setpoint_ff > min_setpoint) begin
                     setpoint_in = (setpoint_ff >= STEP_SIZE) ? setpoint_ff - STEP_SIZE : '0;
                     moved       = 1'b1;
                  end
               end
               CMD_LEAVE: begin
                  setting_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
      if (sp_load) begin
         setpoint_in = sp_load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         sum_ff      <= '0;
         latest_ff   <= '0;
         setpoint_ff <= INITIAL_SETPOINT_RST;
         setting_ff  <= 1'b0;
         primed_ff   <= 1'b0;
      end else begin
         slot_ff     <= slot_in;
         sum_ff      <= sum_in;
         latest_ff   <= latest_in;
         setpoint_ff <= setpoint_in;
         setting_ff  <= setting_in;
         primed_ff   <= primed_in;
      end
   end

   // first sample floods the whole window
   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         if (do_sample && (!primed_ff || slot_ff == SLOT_W'(i))) begin
            window_ff[i] <= temp;
         end
      end
   end

   // divide by the window size through a scaled reciprocal
   assign product = PROD_W'(sum_ff) * PROD_W'(RECIP);

   assign state.average  = product[RECIP_SHIFT +: TEMP_W];
   assign state.latest   = latest_ff;
   assign state.setpoint = setpoint_ff;
   assign state.setting  = setting_ff;

endmodule

>>> sv/tma_decide.sv
module tma_decide import tma_pkg::*; (
   input  tma_state_type     state,
   input  logic [TEMP_W-1:0] margin,
   input  logic              blink,
   input  logic              moved,
   output tma_result_type    result
);

   logic signed [TEMP_W+1:0] avg_s, sp_s, mrg_s, upper, lower;
   logic                     below_upper, above_lower;

   assign avg_s = $signed({2'b00, state.average});
   assign sp_s  = $signed({2'b00, state.setpoint});
   assign mrg_s = $signed({2'b00, margin});
   assign upper = avg_s + mrg_s;
   assign lower = avg_s - mrg_s;

   assign below_upper = sp_s < upper;
   assign above_lower = sp_s > lower;

   always_comb begin
      result.heater_on        = 1'b0;
      result.cooler_on        = 1'b0;
      result.lamp_on          = 1'b0;
      result.in_setting       = state.setting;
      result.current_setpoint = state.setpoint;
      result.average_temp     = state.average;
      if (state.setting) begin
         result.display_on    = blink || moved;
         result.display_value = state.setpoint;
      end else begin
         result.display_on    = 1'b1;
         result.display_value = state.latest;
         if (below_upper && !above_lower) begin
            result.cooler_on = 1'b1;
            result.lamp_on   = 1'b1;
         end else if (!below_upper && above_lower) begin
            result.heater_on = 1'b1;
            result.lamp_on   = blink;
         end
      end
   end

endmodule

>>> sv/thermostat_with_moving_average.sv
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_stall  command, adc_reading, blink
// rsp       out        rsp_valid/rsp_stall  drives, display, mode, setpoint, average
// csr       in         csr_write            csr_index, csr_data
//
// One word per cycle while rsp_stall allows. State updates as the request is taken; the
// middle stage then divides the window sum by a reciprocal multiply and decides the
// drives into the result register when that register is free.
// Synchronous reset restores register defaults and empties both stages.
// A stalled result holds one word in the middle stage before req_stall rises.
module thermostat_with_moving_average import tma_pkg::*; #(
   parameter int WINDOW_SIZE = TMA_WINDOW_SIZE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [9:0]        req_adc_reading,
   input  logic              req_blink,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_heater_on,
   output logic              rsp_cooler_on,
   output logic              rsp_lamp_on,
   output logic              rsp_display_on,
   output logic [TEMP_W-1:0] rsp_display_value,
   output logic              rsp_in_setting,
   output logic [TEMP_W-1:0] rsp_current_setpoint,
   output logic [TEMP_W-1:0] rsp_average_temp,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [TEMP_W-1:0] csr_data
);

   logic [TEMP_W-1:0] min_sp_ff, min_sp_in;
   logic [TEMP_W-1:0] max_sp_ff, max_sp_in;
   logic [TEMP_W-1:0] margin_ff, margin_in;
   logic              sp_load;

   logic              mid_valid_ff, mid_valid_in;
   logic              mid_blink_ff, mid_blink_in;
   logic              mid_moved_ff, mid_moved_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tma_result_type    rsp_data_ff, rsp_data_in;

   logic              accept, rsp_free, mid_advance, moved;
   tma_state_type     state;
   tma_result_type    result;

   always_comb begin
      min_sp_in = min_sp_ff;
      max_sp_in = max_sp_ff;
      margin_in = margin_ff;
      sp_load   = 1'b0;
      if (csr_write) begin
         case (tma_csr_type'(csr_index))
            CSR_MIN_SETPOINT:     min_sp_in = csr_data;
            CSR_MAX_SETPOINT:     max_sp_in = csr_data;
            CSR_MARGIN:           margin_in = csr_data;
            CSR_INITIAL_SETPOINT: sp_load   = 1'b1;
            default: begin
            end
         endcase
      end
   end

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign mid_advance = mid_valid_ff && rsp_free;
   assign req_stall   = mid_valid_ff && !rsp_free;
   assign accept      = req_valid && !req_stall;

   tma_core #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_command),
      .adc_reading   (req_adc_reading),
      .sp_load       (sp_load),
      .sp_load_value (csr_data),
      .min_setpoint  (min_sp_ff),
      .max_setpoint  (max_sp_ff),
      .state         (state),
      .moved         (moved)
   );

   tma_decide u_decide (
      .state  (state),
      .margin (margin_ff),
      .blink  (mid_blink_ff),
      .moved  (mid_moved_ff),
      .result (result)
   );

   always_comb begin
      mid_valid_in = mid_valid_ff;
      mid_blink_in = mid_blink_ff;
      mid_moved_in = mid_moved_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (mid_advance) begin
         mid_valid_in = 1'b0;
      end
      if (accept) begin
         mid_valid_in = 1'b1;
         mid_blink_in = req_blink;
         mid_moved_in = moved;
      end
      if (rsp_free) begin
         rsp_valid_in = 1'b0;
      end
      if (mid_advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_sp_ff    <= MIN_SETPOINT_RST;
         max_sp_ff    <= MAX_SETPOINT_RST;
         margin_ff    <= MARGIN_RST;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_sp_ff    <= min_sp_in;
         max_sp_ff    <= max_sp_in;
         margin_ff    <= margin_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_blink_ff <= mid_blink_in;
      mid_moved_ff <= mid_moved_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_heater_on        = rsp_data_ff.heater_on;
   assign rsp_cooler_on        = rsp_data_ff.cooler_on;
   assign rsp_lamp_on          = rsp_data_ff.lamp_on;
   assign rsp_display_on       = rsp_data_ff.display_on;
   assign rsp_display_value    = rsp_data_ff.display_value;
   assign rsp_in_setting       = rsp_data_ff.in_setting;
   assign rsp_current_setpoint = rsp_data_ff.current_setpoint;
   assign rsp_average_temp     = rsp_data_ff.average_temp;

endmodule
